/* rtl/core/i2cmbe_pkg.sv */
// Shared types, constants and action tables for the I2C master bit engine.
`timescale 1ns / 1ps

package i2cmbe_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_W         = $clog2(BITS_PER_BYTE + 1);
  localparam int unsigned HOLD_W        = 16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd10;
  localparam logic [7:0]  MSB_MASK      = 8'h80;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Command codes; also the sequencer state (idle when no command runs)
  typedef enum logic [2:0] {
    CMD_IDLE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_SEND_ACK = 3'd5,
    CMD_RECV_ACK = 3'd6
  } cmd_t;

  // Line actions
  typedef enum logic [2:0] {
    ACT_SDA1 = 3'd0,
    ACT_SDA0 = 3'd1,
    ACT_SCL1 = 3'd2,
    ACT_SCL0 = 3'd3,
    ACT_SDAB = 3'd4,
    ACT_SMP  = 3'd5
  } act_t;

  // One classified tick moved from front to back
  typedef struct packed {
    logic       start;
    cmd_t       cmd;
    logic [7:0] shift_init;
    logic       sda;
  } tick_t;

  // Action at a given step of a command
  function automatic act_t act_of(input cmd_t cmd, input logic [1:0] step);
    act_t a;
    a = ACT_SDA1;
    case (cmd)
      CMD_START: begin
        case (step)
          2'd0:    a = ACT_SDA1;
          2'd1:    a = ACT_SCL1;
          2'd2:    a = ACT_SDA0;
          default: a = ACT_SCL0;
        endcase
      end
      CMD_STOP: begin
        case (step)
          2'd0:    a = ACT_SDA0;
          2'd1:    a = ACT_SCL1;
          2'd2:    a = ACT_SDA1;
          default: a = ACT_SDA1;
        endcase
      end
      CMD_WRITE, CMD_SEND_ACK: begin
        case (step)
          2'd0:    a = ACT_SDAB;
          2'd1:    a = ACT_SCL1;
          2'd2:    a = ACT_SCL0;
          default: a = ACT_SDA1;
        endcase
      end
      CMD_READ, CMD_RECV_ACK: begin
        case (step)
          2'd0:    a = ACT_SDA1;
          2'd1:    a = ACT_SCL1;
          2'd2:    a = ACT_SMP;
          default: a = ACT_SCL0;
        endcase
      end
      default: a = ACT_SDA1;
    endcase
    return a;
  endfunction

  // Number of actions in one repetition
  function automatic logic [2:0] act_len(input cmd_t cmd);
    logic [2:0] n;
    case (cmd)
      CMD_START, CMD_READ, CMD_RECV_ACK:  n = 3'd4;
      CMD_STOP, CMD_WRITE, CMD_SEND_ACK:  n = 3'd3;
      default:                            n = 3'd0;
    endcase
    return n;
  endfunction

  // Number of repetitions of the action list
  function automatic logic [BIT_W-1:0] act_reps(input cmd_t cmd);
    logic [BIT_W-1:0] n;
    case (cmd)
      CMD_WRITE, CMD_READ: n = BIT_W'(BITS_PER_BYTE);
      CMD_START, CMD_STOP, CMD_SEND_ACK, CMD_RECV_ACK: n = BIT_W'(1);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/i2c_master_bit_engine_core.sv */
// Top level of the I2C master bit engine: front end, tick queue and sequencer.
`timescale 1ns / 1ps

// Every accepted input item is one tick of the line sequencer and yields one
// result item, so the block takes one item per clock cycle when the output
// side does not stall. Each item passes through the two-entry tick queue and
// then the sequencer, whose state and result register advance once per
// processed tick. A command (start, stop, write byte, read byte, send ack,
// receive ack) is started by a tick that arrives while no command runs; each
// line action then lasts hold_ticks ticks and one extra tick ends the command
// with done_res. The hold time register is written over its own valid/ready
// channel, which is always ready.

module i2c_master_bit_engine_core
  import i2cmbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [HOLD_W-1:0] hold_ticks,
  // tick input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        func,
  input  logic [7:0]        data_byte,
  input  logic              ack_level,
  input  logic              sda_in,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic              scl_out,
  output logic              sda_out,
  output logic              busy_res,
  output logic              done_res,
  output logic [7:0]        read_byte,
  output logic              ack_seen
);

  tick_t in_tick;
  tick_t q_tick;
  logic  q_full;
  logic  q_avail;
  logic  q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  i2cmbe_front u_front (
    .func      (func),
    .data_byte (data_byte),
    .ack_level (ack_level),
    .sda_in    (sda_in),
    .tick      (in_tick)
  );

  i2cmbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_data (in_tick),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_avail),
    .pop_data  (q_tick)
  );

  i2cmbe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_data   (hold_ticks),
    .tick_avail (q_avail),
    .tick       (q_tick),
    .tick_pop   (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_out    (scl_out),
    .sda_out    (sda_out),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_byte  (read_byte),
    .ack_seen   (ack_seen)
  );

endmodule

/* rtl/core/i2cmbe_front.sv */
// Front end: decodes the incoming tick into a command and its preset shift value.
`timescale 1ns / 1ps

module i2cmbe_front
  import i2cmbe_pkg::*;
(
  input  logic [2:0] func,
  input  logic [7:0] data_byte,
  input  logic       ack_level,
  input  logic       sda_in,
  output tick_t      tick
);

  // Classify the selector; unused codes act as a bare tick
  always_comb begin
    tick.sda        = sda_in;
    tick.shift_init = 8'h00;
    case (cmd_t'(func))
      CMD_START, CMD_STOP, CMD_READ, CMD_RECV_ACK: begin
        tick.cmd = cmd_t'(func);
      end
      CMD_WRITE: begin
        tick.cmd        = CMD_WRITE;
        tick.shift_init = data_byte;
      end
      CMD_SEND_ACK: begin
        tick.cmd        = CMD_SEND_ACK;
        tick.shift_init = ack_level ? MSB_MASK : 8'h00;
      end
      default: begin
        tick.cmd = CMD_IDLE;
      end
    endcase
    tick.start = (tick.cmd != CMD_IDLE);
  end

endmodule

/* rtl/core/i2cmbe_queue.sv */
// Short FIFO of classified ticks between the front end and the sequencer.
`timescale 1ns / 1ps

module i2cmbe_queue
  import i2cmbe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  tick_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output tick_t pop_data
);

  tick_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/i2cmbe_back.sv */
// Back end: SCL/SDA action sequencer, hold timer and registered result.
`timescale 1ns / 1ps

module i2cmbe_back
  import i2cmbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic [HOLD_W-1:0] cfg_data,
  input  logic              tick_avail,
  input  tick_t             tick,
  output logic              tick_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              scl_out,
  output logic              sda_out,
  output logic              busy_res,
  output logic              done_res,
  output logic [7:0]        read_byte,
  output logic              ack_seen
);

  logic [HOLD_W-1:0] hold_ticks;
  cmd_t              state, state_next;
  logic [2:0]        step_index, step_next;
  logic [BIT_W-1:0]  bit_index, bit_next;
  logic [7:0]        shift_reg, shift_next;
  logic [HOLD_W-1:0] hold_count, hold_next;
  logic              scl_level, scl_next;
  logic              sda_level, sda_next;
  logic              ack_reg, ack_next;
  logic [7:0]        last_read, last_read_next;
  logic              done_next;
  logic              act_go;
  act_t              act;
  logic [2:0]        bit_pos;
  logic              fire;

  // One tick is processed when one is queued and the result slot is free
  assign fire     = tick_avail && (!out_valid || !out_stall);
  assign tick_pop = fire;

  // Hold time register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_RESET;
    end else if (cfg_wr) begin
      hold_ticks <= cfg_data;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CMD_IDLE;
      step_index <= '0;
      bit_index  <= '0;
      shift_reg  <= '0;
      hold_count <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      ack_reg    <= 1'b1;
      last_read  <= '0;
    end else if (fire) begin
      state      <= state_next;
      step_index <= step_next;
      bit_index  <= bit_next;
      shift_reg  <= shift_next;
      hold_count <= hold_next;
      scl_level  <= scl_next;
      sda_level  <= sda_next;
      ack_reg    <= ack_next;
      last_read  <= last_read_next;
    end
  end

  // Next state: accept, hold, finish or perform the next action
  always_comb begin
    state_next     = state;
    step_next      = step_index;
    bit_next       = bit_index;
    shift_next     = shift_reg;
    hold_next      = hold_count;
    scl_next       = scl_level;
    sda_next       = sda_level;
    ack_next       = ack_reg;
    last_read_next = last_read;
    done_next      = 1'b0;
    act_go         = 1'b0;

    if (state == CMD_IDLE) begin
      if (tick.start) begin
        state_next = tick.cmd;
        step_next  = '0;
        bit_next   = '0;
        shift_next = tick.shift_init;
        act_go     = 1'b1;
      end
    end else if (hold_count != '0) begin
      hold_next = hold_count - 1'b1;
    end else if (bit_index >= act_reps(state)) begin
      if (state == CMD_READ) begin
        last_read_next = shift_reg;
      end
      state_next = CMD_IDLE;
      step_next  = '0;
      bit_next   = '0;
      done_next  = 1'b1;
    end else begin
      act_go = 1'b1;
    end

    // Action on the line, from the values just selected
    act     = act_of(state_next, step_next[1:0]);
    bit_pos = 3'(BITS_PER_BYTE - 1) - bit_next[2:0];
    if (act_go) begin
      case (act)
        ACT_SDA1: sda_next = 1'b1;
        ACT_SDA0: sda_next = 1'b0;
        ACT_SCL1: scl_next = 1'b1;
        ACT_SCL0: scl_next = 1'b0;
        ACT_SDAB: sda_next = shift_next[bit_pos];
        ACT_SMP: begin
          if (state_next == CMD_READ) begin
            shift_next = {shift_next[6:0], tick.sda};
          end else begin
            ack_next = tick.sda;
          end
        end
        default: sda_next = sda_level;
      endcase
      hold_next = (hold_ticks == '0) ? '0 : hold_ticks - 1'b1;
      if (step_next + 3'd1 >= act_len(state_next)) begin
        step_next = '0;
        bit_next  = bit_next + 1'b1;
      end else begin
        step_next = step_next + 3'd1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      scl_out   <= scl_next;
      sda_out   <= sda_next;
      busy_res  <= (state_next != CMD_IDLE);
      done_res  <= done_next;
      read_byte <= last_read_next;
      ack_seen  <= ack_next;
    end
  end

  // A finishing tick never reports busy
  assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while busy");

  // The hold timer only runs inside a command
  assert property (@(posedge clk) disable iff (rst)
    hold_count != '0 |-> state != CMD_IDLE)
    else $error("hold timer running while idle");

  // Bit counter never passes the byte length
  assert property (@(posedge clk) disable iff (rst)
    bit_index <= BIT_W'(BITS_PER_BYTE))
    else $error("bit counter out of range");

  // Sequencer state moves only on a processed tick
  assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(state) && $stable(hold_count))
    else $error("sequencer moved without a tick");

endmodule

/* sim/i2c_master_bit_engine_core_test.sv */
// Self-checking testbench for the I2C master bit engine core.
`timescale 1ns / 1ps

module i2c_master_bit_engine_core_test;
  import i2cmbe_pkg::*;

  // Selector value with no command behind it
  localparam logic [2:0] SEL_SEVEN = 3'd7;

  // How pad ticks drive the sampled SDA level
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  // Least number of commands issued per random phase
  localparam int PHASE_CMDS = 3;

  // One result transfer
  typedef struct {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rd;
    logic       ack;
  } line_levels_t;

  // Tracks the line sequencer tick by tick and holds the levels still due
  class line_book;
    logic [HOLD_W-1:0] hold_cfg;
    cmd_t              cmd_q;
    logic [2:0]        step_n;
    logic [3:0]        bit_n;
    logic [7:0]        shifter;
    logic [HOLD_W-1:0] hold_left;
    logic              scl, sda, ack_bit;
    logic [7:0]        last_rd;
    line_levels_t      levels_due[$];
    int                miscompares;

    function new();
      hold_cfg    = HOLD_RESET;
      cmd_q       = CMD_IDLE;
      step_n      = '0;
      bit_n       = '0;
      shifter     = '0;
      hold_left   = '0;
      scl         = 1'b1;
      sda         = 1'b1;
      ack_bit     = 1'b1;
      last_rd     = '0;
      miscompares = 0;
    endfunction

    function bit busy();
      return cmd_q != CMD_IDLE;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function act_t action_at(cmd_t c, logic [1:0] s);
      act_t a;
      a = ACT_SDA1;
      case (c)
        CMD_START: begin
          case (s)
            2'd0:    a = ACT_SDA1;
            2'd1:    a = ACT_SCL1;
            2'd2:    a = ACT_SDA0;
            default: a = ACT_SCL0;
          endcase
        end
        CMD_STOP: begin
          case (s)
            2'd0:    a = ACT_SDA0;
            2'd1:    a = ACT_SCL1;
            default: a = ACT_SDA1;
          endcase
        end
        CMD_WRITE, CMD_SEND_ACK: begin
          case (s)
            2'd0:    a = ACT_SDAB;
            2'd1:    a = ACT_SCL1;
            default: a = ACT_SCL0;
          endcase
        end
        default: begin
          case (s)
            2'd0:    a = ACT_SDA1;
            2'd1:    a = ACT_SCL1;
            2'd2:    a = ACT_SMP;
            default: a = ACT_SCL0;
          endcase
        end
      endcase
      return a;
    endfunction

    function int steps_in(cmd_t c);
      return (c == CMD_START || c == CMD_READ || c == CMD_RECV_ACK) ? 4 : 3;
    endfunction

    function int reps_of(cmd_t c);
      return (c == CMD_WRITE || c == CMD_READ) ? BITS_PER_BYTE : 1;
    endfunction

    // One line action, then its hold starts
    function void act_once(logic s);
      case (action_at(cmd_q, step_n[1:0]))
        ACT_SDA1: sda = 1'b1;
        ACT_SDA0: sda = 1'b0;
        ACT_SCL1: scl = 1'b1;
        ACT_SCL0: scl = 1'b0;
        ACT_SDAB: sda = shifter[3'd7 - bit_n[2:0]];
        default: begin
          if (cmd_q == CMD_READ) shifter = {shifter[6:0], s};
          else ack_bit = s;
        end
      endcase
      // a zero hold behaves as a single tick
      hold_left = (hold_cfg == '0) ? '0 : hold_cfg - 1'b1;
      step_n = step_n + 1'b1;
      if (int'(step_n) >= steps_in(cmd_q)) begin
        step_n = '0;
        bit_n  = bit_n + 1'b1;
      end
    endfunction

    // Accepted input transfer: advance one tick and queue the levels it gives
    function void take_tick(logic [2:0] f, logic [7:0] d, logic a, logic s);
      logic ended;
      ended = 1'b0;
      if (cmd_q == CMD_IDLE) begin
        if (f != CMD_IDLE && f != SEL_SEVEN) begin
          cmd_q  = cmd_t'(f);
          step_n = '0;
          bit_n  = '0;
          if (cmd_q == CMD_WRITE) shifter = d;
          else if (cmd_q == CMD_SEND_ACK) shifter = a ? MSB_MASK : 8'h00;
          else shifter = 8'h00;
          act_once(s);
        end
      end else if (hold_left != '0) begin
        hold_left = hold_left - 1'b1;
      end else if (int'(bit_n) >= reps_of(cmd_q)) begin
        if (cmd_q == CMD_READ) last_rd = shifter;
        cmd_q  = CMD_IDLE;
        step_n = '0;
        bit_n  = '0;
        ended  = 1'b1;
      end else begin
        act_once(s);
      end
      levels_due.push_back('{scl, sda, cmd_q != CMD_IDLE, ended, last_rd, ack_bit});
    endfunction

    function void field_cmp(string what, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        miscompares++;
        if (miscompares <= 10)
          $display("mismatch on %s: expected %0h, got %0h", what, want, seen);
      end
    endfunction

    // Accepted result transfer against the oldest outstanding levels
    function void check_levels(line_levels_t got);
      line_levels_t want;
      if (levels_due.size() == 0) begin
        miscompares++;
        if (miscompares <= 10) $display("result transfer with nothing outstanding");
      end else begin
        want = levels_due.pop_front();
        field_cmp("scl_out", {7'd0, want.scl}, {7'd0, got.scl});
        field_cmp("sda_out", {7'd0, want.sda}, {7'd0, got.sda});
        field_cmp("busy_res", {7'd0, want.busy}, {7'd0, got.busy});
        field_cmp("done_res", {7'd0, want.done}, {7'd0, got.done});
        field_cmp("read_byte", want.rd, got.rd);
        field_cmp("ack_seen", {7'd0, want.ack}, {7'd0, got.ack});
      end
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [HOLD_W-1:0] hold_ticks = '0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [2:0]        func       = '0;
  logic [7:0]        data_byte  = '0;
  logic              ack_level  = 1'b0;
  logic              sda_in     = 1'b0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic              scl_out;
  logic              sda_out;
  logic              busy_res;
  logic              done_res;
  logic [7:0]        read_byte;
  logic              ack_seen;

  line_book book = new();
  bit       calm = 1'b0;
  int       cmds_issued = 0;

  i2c_master_bit_engine_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .hold_ticks (hold_ticks),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .data_byte  (data_byte),
    .ack_level  (ack_level),
    .sda_in     (sda_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_out    (scl_out),
    .sda_out    (sda_out),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_byte  (read_byte),
    .ack_seen   (ack_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Output side back-pressure
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 9);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      book.check_levels('{scl_out, sda_out, busy_res, done_res, read_byte, ack_seen});
  end

  function logic sda_pick(int mode);
    if (mode == SDA_LOW) return 1'b0;
    if (mode == SDA_HIGH) return 1'b1;
    return 1'($urandom);
  endfunction

  // One input transfer; called at a falling edge, returns at a falling edge
  task push_tick(logic [2:0] f, logic [7:0] d, logic a, logic s);
    if (!calm) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid  <= 1'b1;
    func      <= f;
    data_byte <= d;
    ack_level <= a;
    sda_in    <= s;
    do @(posedge clk); while (in_stall);
    book.take_tick(f, d, a, s);
    @(negedge clk);
  endtask

  // Issue a command, then feed ticks until it completes
  task run_cmd(logic [2:0] f, logic [7:0] d, logic a, int mode);
    if (f != CMD_IDLE && f != SEL_SEVEN) cmds_issued++;
    push_tick(f, d, a, sda_pick(mode));
    // pad ticks carry random selectors, which a running command ignores
    while (book.busy())
      push_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), sda_pick(mode));
  endtask

  // Stop sending and let every outstanding result drain
  task settle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task load_hold(logic [HOLD_W-1:0] v);
    cfg_valid  <= 1'b1;
    hold_ticks <= v;
    do @(posedge clk); while (!cfg_ready);
    book.hold_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Address, ack, a few data bytes, mostly closed by a stop; some plain noise
  task bus_transaction();
    int  nbytes;
    int  k;
    bit  rd;
    if ($urandom_range(0, 99) < 15) begin
      run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), SDA_RAND);
      return;
    end
    rd = 1'($urandom);
    nbytes = $urandom_range(0, 3);
    run_cmd(CMD_START, 8'($urandom), 1'($urandom), SDA_RAND);
    run_cmd(CMD_WRITE, {7'($urandom), rd}, 1'($urandom), SDA_RAND);
    run_cmd(CMD_RECV_ACK, 8'($urandom), 1'($urandom), SDA_RAND);
    for (k = 0; k < nbytes; k++) begin
      if (rd) begin
        run_cmd(CMD_READ, 8'($urandom), 1'($urandom), SDA_RAND);
        run_cmd(CMD_SEND_ACK, 8'($urandom), (k == nbytes - 1) ? 1'b1 : 1'($urandom),
                SDA_RAND);
      end else begin
        run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RAND);
        run_cmd(CMD_RECV_ACK, 8'($urandom), 1'($urandom), SDA_RAND);
      end
    end
    // otherwise the next transaction opens with a repeated start
    if ($urandom_range(0, 9) != 0)
      run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RAND);
  endtask

  // Stimulus
  initial begin
    int phase;
    int goal;
    logic [HOLD_W-1:0] hv;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset hold value
    run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND);
    settle();
    load_hold(16'd1);

    // tick only and the unused selector while idle
    push_tick(CMD_IDLE, 8'hFF, 1'b1, 1'b1);
    push_tick(SEL_SEVEN, 8'h00, 1'b0, 1'b0);
    run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_RAND);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_RAND);
    run_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND);
    run_cmd(CMD_READ, 8'hFF, 1'b0, SDA_LOW);
    run_cmd(CMD_READ, 8'h00, 1'b0, SDA_HIGH);
    run_cmd(CMD_READ, 8'h00, 1'b1, SDA_RAND);
    run_cmd(CMD_SEND_ACK, 8'hFF, 1'b0, SDA_RAND);
    run_cmd(CMD_SEND_ACK, 8'h00, 1'b1, SDA_RAND);
    run_cmd(CMD_RECV_ACK, 8'h00, 1'b0, SDA_LOW);
    run_cmd(CMD_RECV_ACK, 8'h00, 1'b0, SDA_HIGH);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND);

    // zero hold acts as one tick
    settle();
    load_hold(16'd0);
    run_cmd(CMD_START, 8'h3C, 1'b0, SDA_RAND);
    run_cmd(CMD_READ, 8'h00, 1'b0, SDA_RAND);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND);

    // random bus traffic over several hold settings, one phase without idling
    for (phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0:       hv = 16'd1;
        1:       hv = 16'd2;
        3:       hv = 16'd3;
        default: hv = 16'($urandom_range(1, 4));
      endcase
      load_hold(hv);
      calm = (phase == 2);
      goal = cmds_issued + PHASE_CMDS;
      while (cmds_issued < goal) bus_transaction();
    end

    // long hold: one full stop sequence
    settle();
    calm = 1'b0;
    load_hold(16'd40);
    run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RAND);

    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.miscompares == 0 && book.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* i2c_master_bit_engine_core.f */
rtl/core/i2cmbe_pkg.sv
rtl/core/i2cmbe_front.sv
rtl/core/i2cmbe_queue.sv
rtl/core/i2cmbe_back.sv
rtl/core/i2c_master_bit_engine_core.sv
sim/i2c_master_bit_engine_core_test.sv
